### hw/rtl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Types and constants shared by the alarm mode controller.
// ----------------------------------------------------------------------------
package amc_pkg;

    localparam int unsigned TICK_W     = 10;
    localparam int unsigned LIMIT_W    = 24;
    localparam int unsigned BLINK_W    = 16;
    localparam int unsigned ON_TIME_W  = 26;
    localparam int unsigned BTIME_W    = 17;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = TICK_W'(100);
    localparam logic [LIMIT_W-1:0] MAX_ON_RST      = LIMIT_W'(60000);
    localparam logic [LIMIT_W-1:0] SHORT_BEEP_RST  = LIMIT_W'(500);
    localparam logic [BLINK_W-1:0] BLINK_HALF_RST  = BLINK_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_BEEP  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF  = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        MODE_OFF          = 3'd0,
        MODE_LED_ON       = 3'd1,
        MODE_BLINK        = 3'd2,
        MODE_BUZZER       = 3'd3,
        MODE_BLINK_BUZZER = 3'd4,
        MODE_SHORT_BEEP   = 3'd5
    } mode_t;

    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_OK      = 2'd1;
    localparam logic [1:0] ACK_INVALID = 2'd2;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       has_switch;
        logic [7:0] switch_value;
        logic       has_mode;
        logic [7:0] mode_value;
    } cmd_word_t;

    typedef struct packed {
        logic       led_drive;
        logic       buzzer_drive;
        logic       buzzer_tone;
        logic [2:0] current_mode;
        logic       timed_out;
        logic [1:0] ack_code;
        logic       report_due;
    } res_word_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_period_ms;
        logic [LIMIT_W-1:0] max_on_ms;
        logic [LIMIT_W-1:0] short_beep_ms;
        logic [BLINK_W-1:0] blink_half_ms;
    } cfg_t;

endpackage

### hw/rtl/amc_core.sv
// ----------------------------------------------------------------------------
// amc_core
// Mode state, on-time and blink timers; builds the result word for one item.
// ----------------------------------------------------------------------------
module amc_core
    import amc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cmd_word_t item,
    input  cfg_t      cfg,
    output res_word_t result
);

    mode_t                 mode_reg,       mode_next;
    logic                  timeout_reg,    timeout_next;
    logic [ON_TIME_W-1:0]  on_time_reg,    on_time_next;
    logic [BTIME_W-1:0]    blink_time_reg, blink_time_next;
    logic                  phase_reg,      phase_next;

    logic [7:0]            mode_sel;
    logic [ON_TIME_W:0]    on_sum;
    logic [ON_TIME_W-1:0]  on_adv;
    logic [BTIME_W:0]      blink_sum;
    logic [BTIME_W-1:0]    blink_adv;
    logic                  active;
    logic                  blinking;
    logic [1:0]            ack;
    logic                  report;
    logic                  led;
    logic                  buz;

    always_comb
    begin
        mode_next       = mode_reg;
        timeout_next    = timeout_reg;
        on_time_next    = on_time_reg;
        blink_time_next = blink_time_reg;
        phase_next      = phase_reg;
        ack             = ACK_NONE;
        report          = 1'b0;

        if (item.has_switch && item.switch_value == 8'd0)
            mode_sel = 8'(MODE_OFF);
        else if (!item.has_mode)
            mode_sel = 8'(MODE_BLINK_BUZZER);
        else
            mode_sel = item.mode_value;

        active   = (mode_reg != MODE_OFF);
        blinking = (mode_reg inside {MODE_BLINK, MODE_BLINK_BUZZER});

        on_sum    = {1'b0, on_time_reg} + (ON_TIME_W+1)'(cfg.tick_period_ms);
        on_adv    = on_sum[ON_TIME_W] ? {ON_TIME_W{1'b1}} : on_sum[ON_TIME_W-1:0];
        blink_sum = {1'b0, blink_time_reg} + (BTIME_W+1)'(cfg.tick_period_ms);
        blink_adv = blink_sum[BTIME_W] ? {BTIME_W{1'b1}} : blink_sum[BTIME_W-1:0];

        if (item.opcode == OP_COMMAND)
        begin
            if (mode_sel > 8'(MODE_SHORT_BEEP))
            begin
                ack = ACK_INVALID;
            end
            else
            begin
                ack             = ACK_OK;
                report          = 1'b1;
                mode_next       = mode_t'(mode_sel[2:0]);
                timeout_next    = 1'b0;
                on_time_next    = '0;
                blink_time_next = '0;
                phase_next      = 1'b1;
            end
        end
        else
        begin
            if (active)
                on_time_next = on_adv;
            if (blinking)
            begin
                if (blink_adv >= BTIME_W'(cfg.blink_half_ms))
                begin
                    blink_time_next = '0;
                    phase_next      = ~phase_reg;
                end
                else
                begin
                    blink_time_next = blink_adv;
                end
            end
            if (mode_reg == MODE_SHORT_BEEP &&
                on_time_next >= ON_TIME_W'(cfg.short_beep_ms))
            begin
                report          = 1'b1;
                mode_next       = MODE_OFF;
                timeout_next    = 1'b0;
                on_time_next    = '0;
                blink_time_next = '0;
                phase_next      = 1'b1;
            end
            else if (active && on_time_next >= ON_TIME_W'(cfg.max_on_ms))
            begin
                report          = 1'b1;
                mode_next       = MODE_OFF;
                timeout_next    = 1'b1;
                on_time_next    = '0;
                blink_time_next = '0;
                phase_next      = 1'b1;
            end
        end
    end

    always_comb
    begin
        led = 1'b0;
        buz = 1'b0;
        case (mode_next)
            MODE_LED_ON:       led = 1'b1;
            MODE_BLINK:        led = phase_next;
            MODE_BUZZER:       buz = 1'b1;
            MODE_BLINK_BUZZER:
            begin
                led = phase_next;
                buz = 1'b1;
            end
            MODE_SHORT_BEEP:   buz = 1'b1;
            default:           ;
        endcase
    end

    always_comb
    begin
        result.led_drive    = led;
        result.buzzer_drive = buz;
        result.buzzer_tone  = buz;
        result.current_mode = mode_next;
        result.timed_out    = timeout_next;
        result.ack_code     = ack;
        result.report_due   = report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            timeout_reg    <= 1'b0;
            on_time_reg    <= '0;
            blink_time_reg <= '0;
            phase_reg      <= 1'b1;
        end
        else if (en)
        begin
            mode_reg       <= mode_next;
            timeout_reg    <= timeout_next;
            on_time_reg    <= on_time_next;
            blink_time_reg <= blink_time_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

### hw/rtl/alarm_mode_controller.sv
// ----------------------------------------------------------------------------
// alarm_mode_controller
// Alarm LED and buzzer mode controller: ticks and commands in, one status
// word out per item.
//
// cmd channel: cmd_valid / cmd_stall / cmd_word. Each word is a tick or a
// decoded control command.
// res channel: res_valid / res_stall / res_word. Exactly one result word per
// command word, in order.
// cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready.
// Index 0 tick period, 1 max on-time, 2 short beep time, 3 blink half period;
// other indexes are ignored. Write only while the block is idle.
// Path: the input register holds the accepted word; the result register then
// takes its result after one pass of the update logic.
// Throughput: one word per cycle while the receiver does not stall; the mode
// and timer update is a single add-and-compare pass.
// Receiver stall: the result register holds; cmd_stall rises when the input
// register is full and cannot move on, so nothing is dropped.
// Reset: mode off, timers clear, blink phase on, config registers at defaults.
// ----------------------------------------------------------------------------
module alarm_mode_controller
    import amc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_word_t             cmd_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_word_t             res_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    cmd_word_t s1_word_reg;
    logic      res_valid_reg;
    res_word_t res_word_reg;
    res_word_t core_result;
    logic      res_free;
    logic      advance;

    assign res_free  = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && res_free;
    assign cmd_stall = s1_valid_reg && !res_free;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    amc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (s1_word_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period_ms <= TICK_PERIOD_RST;
            cfg_reg.max_on_ms      <= MAX_ON_RST;
            cfg_reg.short_beep_ms  <= SHORT_BEEP_RST;
            cfg_reg.blink_half_ms  <= BLINK_HALF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TICK_PERIOD: cfg_reg.tick_period_ms <= cfg_data[TICK_W-1:0];
                CFG_MAX_ON:      cfg_reg.max_on_ms      <= cfg_data[LIMIT_W-1:0];
                CFG_SHORT_BEEP:  cfg_reg.short_beep_ms  <= cfg_data[LIMIT_W-1:0];
                CFG_BLINK_HALF:  cfg_reg.blink_half_ms  <= cfg_data[BLINK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
                s1_valid_reg <= cmd_valid;
            if (res_free)
                res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            s1_word_reg <= cmd_word;
        if (advance)
            res_word_reg <= core_result;
    end

endmodule
